/* rtl/nvld_pkg.sv */
// Package: payload types and fixed-point widths for the nearest-vertex dz search.
`timescale 1ns / 1ps
`default_nettype none

package nvld_pkg;

  // field widths
  localparam int POS_W = 24;                 // positions, LSB 1/1024 cm
  localparam int MOM_W = 24;                 // momenta, LSB 1/4096 GeV
  localparam int WIN_W = 23;                 // |dz| window
  localparam logic [WIN_W-1:0] RESET_WINDOW = 23'd1022976;  // 999 cm

  // internal widths
  localparam int DIF_W  = POS_W + 1;         // track minus vertex
  localparam int SUM_W  = DIF_W + 3;         // serial multiply adder width
  localparam int HI_W   = SUM_W - 1;         // high half of serial accumulator
  localparam int NUM_W  = HI_W + MOM_W;      // signed dot product
  localparam int MAG_W  = NUM_W - 1;         // |dot product|
  localparam int PZM_W  = MOM_W;             // |pz|, holds 2^23
  localparam int PROD_W = MAG_W + PZM_W;     // |num| * |pz|
  localparam int DVS_W  = 48;                // px^2 + py^2
  localparam int QSH    = 40;                // quotient clamp 2^40
  localparam int Q_W    = QSH + 1;
  localparam int REM0_W = PROD_W - QSH;      // dividend bits above the clamp
  localparam int DZF_W  = Q_W + 2;           // full dz before saturation
  localparam int CNT_W  = 6;

  localparam int DOT_STEPS = MOM_W;
  localparam int MUL_STEPS = PZM_W;
  localparam int DIV_STEPS = QSH;

  typedef struct packed {
    logic signed [POS_W-1:0] track_x;
    logic signed [POS_W-1:0] track_y;
    logic signed [POS_W-1:0] track_z;
    logic signed [MOM_W-1:0] dir_x;
    logic signed [MOM_W-1:0] dir_y;
    logic signed [MOM_W-1:0] dir_z;
    logic signed [POS_W-1:0] vtx_x;
    logic signed [POS_W-1:0] vtx_y;
    logic signed [POS_W-1:0] vtx_z;
    logic                    last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] best_x;
    logic signed [POS_W-1:0] best_y;
    logic signed [POS_W-1:0] best_z;
    logic signed [POS_W-1:0] best_dz;
    logic                    found;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/nearest_vertex_by_longitudinal_distance.sv */
// Top level: bit-serial track-to-vertex association by longitudinal distance.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | ports                          | transfer when
//  ---------+--------------------------------+-------------------------------
//  input    | in_valid, in_ready, in_data    | in_valid && in_ready
//  result   | out_valid, out_ready, out_data | out_valid && out_ready
//  config   | cfg_we, cfg_wdata              | cfg_we (dz_window, no wait)
//
//  A vertex holds in_ready low from its transfer until it leaves the update: 24 bit-serial
//  dot-product steps, a magnitude step, 24 multiply steps by |pz|, a clamp test,
//  40 restoring divide steps, a dz step and the update; the divide sets the rate.
//  Zero pt^2 goes straight to the update; a clamped quotient skips the
//  divide. Reset (rst_n low, synchronous) restores the 999 cm window.
//  A last vertex waits in the update while the output register holds an untaken result.

module nearest_vertex_by_longitudinal_distance (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire nvld_pkg::in_item_t     in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output nvld_pkg::out_item_t         out_data,
  input  wire logic                   cfg_we,
  input  wire logic [nvld_pkg::WIN_W-1:0] cfg_wdata
);

  localparam int POS_W  = nvld_pkg::POS_W;
  localparam int MOM_W  = nvld_pkg::MOM_W;
  localparam int WIN_W  = nvld_pkg::WIN_W;
  localparam int DIF_W  = nvld_pkg::DIF_W;
  localparam int SUM_W  = nvld_pkg::SUM_W;
  localparam int HI_W   = nvld_pkg::HI_W;
  localparam int NUM_W  = nvld_pkg::NUM_W;
  localparam int MAG_W  = nvld_pkg::MAG_W;
  localparam int PZM_W  = nvld_pkg::PZM_W;
  localparam int DVS_W  = nvld_pkg::DVS_W;
  localparam int QSH    = nvld_pkg::QSH;
  localparam int Q_W    = nvld_pkg::Q_W;
  localparam int REM0_W = nvld_pkg::REM0_W;
  localparam int DZF_W  = nvld_pkg::DZF_W;
  localparam int CNT_W  = nvld_pkg::CNT_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DOT  = 3'd1;
  localparam logic [2:0] S_ABS  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OVF  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DZ   = 3'd6;
  localparam logic [2:0] S_UPD  = 3'd7;

  localparam logic [CNT_W-1:0] DOT_LAST = CNT_W'(nvld_pkg::DOT_STEPS - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(nvld_pkg::MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(nvld_pkg::DIV_STEPS - 1);

  localparam logic signed [POS_W-1:0] DZ_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] DZ_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // control
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;

  // captured item
  logic signed [DIF_W-1:0] dx_r, dy_r, dzr_r;
  logic signed [MOM_W-1:0] px_r, py_r;
  logic [MOM_W-1:0]        px_sr, py_sr;     // multiplier bits, LSB first
  logic                    pz_neg_r;
  logic [PZM_W-1:0]        mpl_sr;           // |pz|, LSB first
  logic signed [POS_W-1:0] vx_r, vy_r, vz_r;
  logic                    last_r;

  // serial accumulators: {hi, lo}
  logic signed [HI_W-1:0]  nhi_r, dhi_r;
  logic [MOM_W-1:0]        nlo_r, dlo_r;
  logic                    sign_r;
  logic [MAG_W-1:0]        mcand_r, phi_r;
  logic [PZM_W-1:0]        plo_r;
  logic [DVS_W-1:0]        dvs_r;
  logic [DVS_W-1:0]        rem_r;
  logic [QSH-1:0]          div_sr;
  logic [Q_W-1:0]          q_r;
  logic signed [POS_W-1:0] dz_r;
  logic                    elig_r;

  // run state
  logic [WIN_W-1:0]        win_r, min_abs_dz_r;
  logic signed [POS_W-1:0] chosen_x_r, chosen_y_r, chosen_z_r, chosen_dz_r;
  logic                    have_choice_r;
  nvld_pkg::out_item_t     out_data_r;

  logic in_fire, out_free;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // dot-product step: one bit of px and py per cycle, MSB weight negative
  logic signed [SUM_W-1:0] ax, ay, bx, by, addn, addd, sn, sd;
  logic                    msb_step;
  always_comb begin
    msb_step = (cnt_r == DOT_LAST);
    ax   = px_sr[0] ? SUM_W'(dx_r) : '0;
    ay   = py_sr[0] ? SUM_W'(dy_r) : '0;
    bx   = px_sr[0] ? SUM_W'(px_r) : '0;
    by   = py_sr[0] ? SUM_W'(py_r) : '0;
    addn = ax + ay;
    addd = bx + by;
    sn   = msb_step ? (SUM_W'(nhi_r) - addn) : (SUM_W'(nhi_r) + addn);
    sd   = msb_step ? (SUM_W'(dhi_r) - addd) : (SUM_W'(dhi_r) + addd);
  end

  // magnitude of the dot product
  logic [NUM_W-1:0] num_w, num_mag;
  logic [DVS_W-1:0] pt2_w;
  always_comb begin
    num_w   = {nhi_r, nlo_r};
    num_mag = nhi_r[HI_W-1] ? (~num_w + NUM_W'(1)) : num_w;
    pt2_w   = DVS_W'({dhi_r, dlo_r});
  end

  // multiply step
  logic [MAG_W:0] sm;
  assign sm = {1'b0, phi_r} + (mpl_sr[0] ? {1'b0, mcand_r} : '0);

  // clamp test: quotient bits at or above 2^40 mean the clamp applies
  logic [DVS_W-1:0] rem0;
  logic             ovf;
  assign rem0 = DVS_W'(phi_r[MAG_W-1 -: REM0_W]);
  assign ovf  = (rem0 >= dvs_r);

  // restoring divide step
  logic [DVS_W:0] t, tr;
  logic           ge;
  always_comb begin
    t  = {rem_r, div_sr[QSH-1]};
    tr = t - {1'b0, dvs_r};
    ge = (t >= {1'b0, dvs_r});
  end

  // dz with saturation
  logic signed [DZF_W-1:0] qe, term, dzf;
  logic signed [POS_W-1:0] dz_sat;
  always_comb begin
    qe   = DZF_W'(q_r);
    term = sign_r ? -qe : qe;
    dzf  = DZF_W'(dzr_r) - term;
    if (dzf[DZF_W-1:POS_W-1] == '0 || dzf[DZF_W-1:POS_W-1] == '1) begin
      dz_sat = dzf[POS_W-1:0];
    end else if (dzf[DZF_W-1]) begin
      dz_sat = DZ_MIN;
    end else begin
      dz_sat = DZ_MAX;
    end
  end

  // update: strictly smaller keeps the earlier vertex on a tie
  logic [POS_W-1:0] absdz;
  logic             better;
  logic signed [POS_W-1:0] nx, ny, nz, ndz;
  logic [WIN_W-1:0] nmin;
  logic             nhave;
  always_comb begin
    absdz  = dz_r[POS_W-1] ? (~dz_r + POS_W'(1)) : dz_r;
    better = elig_r && (absdz < {1'b0, min_abs_dz_r});
    nx     = better ? vx_r : chosen_x_r;
    ny     = better ? vy_r : chosen_y_r;
    nz     = better ? vz_r : chosen_z_r;
    ndz    = better ? dz_r : chosen_dz_r;
    nmin   = better ? absdz[WIN_W-1:0] : min_abs_dz_r;
    nhave  = better || have_choice_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) state_nxt = S_DOT;
      end
      S_DOT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DOT_LAST) state_nxt = S_ABS;
      end
      S_ABS: begin
        cnt_nxt   = '0;
        state_nxt = (pt2_w == '0) ? S_UPD : S_MUL;
      end
      S_MUL: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == MUL_LAST) state_nxt = S_OVF;
      end
      S_OVF: begin
        cnt_nxt   = '0;
        state_nxt = ovf ? S_DZ : S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) state_nxt = S_DZ;
      end
      S_DZ: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!last_r || out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      win_r         <= nvld_pkg::RESET_WINDOW;
      min_abs_dz_r  <= nvld_pkg::RESET_WINDOW;
      chosen_x_r    <= '0;
      chosen_y_r    <= '0;
      chosen_z_r    <= '0;
      chosen_dz_r   <= '0;
      have_choice_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_UPD && last_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) win_r <= cfg_wdata;
      if (state_r == S_UPD && last_r && out_free) begin
        // close the run; a window written now opens the next one
        min_abs_dz_r  <= cfg_we ? cfg_wdata : win_r;
        chosen_x_r    <= '0;
        chosen_y_r    <= '0;
        chosen_z_r    <= '0;
        chosen_dz_r   <= '0;
        have_choice_r <= 1'b0;
      end else if (state_r == S_UPD && !last_r) begin
        min_abs_dz_r  <= (cfg_we && !nhave) ? cfg_wdata : nmin;
        chosen_x_r    <= nx;
        chosen_y_r    <= ny;
        chosen_z_r    <= nz;
        chosen_dz_r   <= ndz;
        have_choice_r <= nhave;
      end else if (cfg_we && !have_choice_r) begin
        // window write: reload the running minimum only before any choice
        min_abs_dz_r <= cfg_wdata;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          dx_r     <= DIF_W'(in_data.track_x) - DIF_W'(in_data.vtx_x);
          dy_r     <= DIF_W'(in_data.track_y) - DIF_W'(in_data.vtx_y);
          dzr_r    <= DIF_W'(in_data.track_z) - DIF_W'(in_data.vtx_z);
          px_r     <= in_data.dir_x;
          py_r     <= in_data.dir_y;
          px_sr    <= in_data.dir_x;
          py_sr    <= in_data.dir_y;
          pz_neg_r <= in_data.dir_z[MOM_W-1];
          mpl_sr   <= in_data.dir_z[MOM_W-1] ? (~in_data.dir_z + PZM_W'(1))
                                             : in_data.dir_z;
          vx_r     <= in_data.vtx_x;
          vy_r     <= in_data.vtx_y;
          vz_r     <= in_data.vtx_z;
          last_r   <= in_data.last_vertex;
          nhi_r    <= '0;
          dhi_r    <= '0;
        end
      end
      S_DOT: begin
        nhi_r <= sn[SUM_W-1:1];
        nlo_r <= {sn[0], nlo_r[MOM_W-1:1]};
        dhi_r <= sd[SUM_W-1:1];
        dlo_r <= {sd[0], dlo_r[MOM_W-1:1]};
        px_sr <= px_sr >> 1;
        py_sr <= py_sr >> 1;
      end
      S_ABS: begin
        mcand_r <= num_mag[MAG_W-1:0];
        sign_r  <= nhi_r[HI_W-1] ^ pz_neg_r;
        dvs_r   <= pt2_w;
        phi_r   <= '0;
        elig_r  <= (pt2_w != '0);
      end
      S_MUL: begin
        phi_r  <= sm[MAG_W:1];
        plo_r  <= {sm[0], plo_r[PZM_W-1:1]};
        mpl_sr <= mpl_sr >> 1;
      end
      S_OVF: begin
        rem_r  <= rem0;
        div_sr <= {phi_r[QSH-PZM_W-1:0], plo_r};
        q_r    <= ovf ? {1'b1, {QSH{1'b0}}} : '0;
      end
      S_DIV: begin
        rem_r  <= ge ? tr[DVS_W-1:0] : t[DVS_W-1:0];
        div_sr <= div_sr << 1;
        q_r    <= {q_r[Q_W-2:0], ge};
      end
      S_DZ: begin
        dz_r <= dz_sat;
      end
      S_UPD: begin
        if (last_r && out_free) begin
          out_data_r.best_x  <= nx;
          out_data_r.best_y  <= ny;
          out_data_r.best_z  <= nz;
          out_data_r.best_dz <= ndz;
          out_data_r.found   <= nhave;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_no_find_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.found |->
      (out_data_r.best_x == '0 && out_data_r.best_y == '0 &&
       out_data_r.best_z == '0 && out_data_r.best_dz == '0))
    else $error("result without a find carries nonzero fields");

  a_min_tracks_win: assert property (@(posedge clk) disable iff (!rst_n)
    !have_choice_r |-> (min_abs_dz_r == win_r))
    else $error("running minimum differs from window before any choice");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second transfer taken while a vertex is in progress");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("divide step count overran");

endmodule

`default_nettype wire
